// ===== rtl/stpt_pkg.sv =====
`timescale 1ns / 1ps

package stpt_pkg;

  // position counter width; the position field shows its low 32 bits
  localparam int unsigned POS_W   = 32;
  // width used for signed position/target compares
  localparam int unsigned CMP_W   = (POS_W > 32) ? POS_W : 32;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TICK_W-1:0] DEFAULT_TICKS = TICK_W'(25);
  localparam logic [TICK_W-1:0] DEFAULT_DEADBAND = TICK_W'(1);

  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_SET_TARGET = 2'd1,
    ACT_WATCH      = 2'd2,
    ACT_ZERO       = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_TICKS    = 3'd0,
    CFG_OFF_TICKS   = 3'd1,
    CFG_UPPER_LIMIT = 3'd2,
    CFG_LOWER_LIMIT = 3'd3,
    CFG_INVERT_DIR  = 3'd4,
    CFG_DEADBAND    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [TICK_W-1:0]         on_ticks;
    logic [TICK_W-1:0]         off_ticks;
    logic signed [FIELD_W-1:0] upper_limit;
    logic signed [FIELD_W-1:0] lower_limit;
    logic                      invert_direction;
    logic [TICK_W-1:0]         deadband;
  } cfg_t;

  typedef struct packed {
    logic                      step_level;
    logic                      dir_level;
    logic signed [FIELD_W-1:0] position;
    logic signed [FIELD_W-1:0] goal;
  } result_t;

endpackage

// ===== rtl/stpt_if.sv =====
`timescale 1ns / 1ps

interface stpt_in_if;
  import stpt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic signed [FIELD_W-1:0] target;

  modport source (output valid, output action, output target, input ready);
  modport sink (input valid, input action, input target, output ready);
endinterface

interface stpt_out_if;
  import stpt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      step_level;
  logic                      dir_level;
  logic signed [FIELD_W-1:0] position;
  logic signed [FIELD_W-1:0] goal;

  modport source (output valid, output step_level, output dir_level, output position,
                  output goal, input ready);
  modport sink (input valid, input step_level, input dir_level, input position,
                input goal, output ready);
endinterface

// ===== rtl/stpt_cfg.sv =====
`timescale 1ns / 1ps

module stpt_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stpt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [stpt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output stpt_pkg::cfg_t                    cfg_o
);
  import stpt_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_ticks         <= DEFAULT_TICKS;
      cfg_q.off_ticks        <= DEFAULT_TICKS;
      cfg_q.upper_limit      <= '0;
      cfg_q.lower_limit      <= '0;
      cfg_q.invert_direction <= 1'b0;
      cfg_q.deadband         <= DEFAULT_DEADBAND;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ON_TICKS:    cfg_q.on_ticks         <= cfg_wdata_i[TICK_W-1:0];
        CFG_OFF_TICKS:   cfg_q.off_ticks        <= cfg_wdata_i[TICK_W-1:0];
        CFG_UPPER_LIMIT: cfg_q.upper_limit      <= cfg_wdata_i[FIELD_W-1:0];
        CFG_LOWER_LIMIT: cfg_q.lower_limit      <= cfg_wdata_i[FIELD_W-1:0];
        CFG_INVERT_DIR:  cfg_q.invert_direction <= cfg_wdata_i[0];
        CFG_DEADBAND:    cfg_q.deadband         <= cfg_wdata_i[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/stpt_engine.sv =====
`timescale 1ns / 1ps

module stpt_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  stpt_pkg::action_e                   act_i,
  input  logic signed [stpt_pkg::FIELD_W-1:0] tgt_i,
  input  stpt_pkg::cfg_t                      cfg_i,
  output stpt_pkg::result_t                   res_o
);
  import stpt_pkg::*;

  logic signed [POS_W-1:0]   pos_q, pos_d;
  logic signed [FIELD_W-1:0] goal_q, goal_d;
  logic [TICK_W-1:0]         timer_q, timer_d;
  logic                      pulse_q, pulse_d;
  logic                      fwd_q, fwd_d;
  logic                      dir_q, dir_d;

  logic signed [CMP_W-1:0]   pos_x, goal_x, new_goal_x, upper_x, lower_x;
  logic signed [CMP_W:0]     diff;
  logic [CMP_W:0]            gap_mag;
  logic                      near;
  logic                      above, below;
  logic                      retgt;
  logic signed [FIELD_W-1:0] new_goal;
  logic                      pos_lt_new;

  assign pos_x   = CMP_W'(pos_q);
  assign goal_x  = CMP_W'(goal_q);
  assign upper_x = CMP_W'(cfg_i.upper_limit);
  assign lower_x = CMP_W'(cfg_i.lower_limit);

  // distance to target, compared against the deadband
  assign diff    = (CMP_W + 1)'(pos_x) - (CMP_W + 1)'(goal_x);
  assign gap_mag = diff[CMP_W] ? (CMP_W + 1)'(-diff) : (CMP_W + 1)'(diff);
  assign near    = gap_mag < (CMP_W + 1)'(cfg_i.deadband);

  assign above = upper_x < pos_x;
  assign below = pos_x < lower_x;

  // target selection; below the window wins over above it
  always_comb begin
    retgt    = 1'b0;
    new_goal = goal_q;
    case (act_i)
      ACT_SET_TARGET: begin
        retgt    = 1'b1;
        new_goal = tgt_i;
      end
      ACT_WATCH: begin
        if (below) begin
          retgt    = 1'b1;
          new_goal = cfg_i.upper_limit + FIELD_W'(1);
        end else if (above) begin
          retgt    = 1'b1;
          new_goal = cfg_i.lower_limit - FIELD_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign new_goal_x = CMP_W'(new_goal);
  assign pos_lt_new = pos_x < new_goal_x;

  always_comb begin
    pos_d   = pos_q;
    goal_d  = goal_q;
    timer_d = timer_q;
    pulse_d = pulse_q;
    fwd_d   = fwd_q;
    dir_d   = dir_q;
    case (act_i)
      ACT_TICK: begin
        if (pulse_q && (timer_q > cfg_i.on_ticks)) begin
          pulse_d = 1'b0;
          timer_d = '0;
        end else if (timer_q > cfg_i.off_ticks) begin
          if (!near) begin
            pos_d   = fwd_q ? pos_q + POS_W'(1) : pos_q - POS_W'(1);
            pulse_d = 1'b1;
          end
          timer_d = '0;
        end else if (timer_q != '1) begin
          timer_d = timer_q + TICK_W'(1);
        end
      end
      ACT_ZERO: begin
        pos_d  = '0;
        goal_d = '0;
      end
      default: begin
      end
    endcase
    if (retgt) begin
      goal_d = new_goal;
      fwd_d  = pos_lt_new;
      dir_d  = cfg_i.invert_direction ^ !pos_lt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      goal_q  <= '0;
      timer_q <= '0;
      pulse_q <= 1'b0;
      fwd_q   <= 1'b1;
      dir_q   <= 1'b0;
    end else if (adv_i) begin
      pos_q   <= pos_d;
      goal_q  <= goal_d;
      timer_q <= timer_d;
      pulse_q <= pulse_d;
      fwd_q   <= fwd_d;
      dir_q   <= dir_d;
    end
  end

  // state registers double as the result register
  assign res_o.step_level = pulse_q;
  assign res_o.dir_level  = dir_q;
  assign res_o.position   = pos_x[FIELD_W-1:0];
  assign res_o.goal       = goal_q;

`ifndef SYNTHESIS
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(pos_q) && $stable(goal_q) && $stable(timer_q))
    else $error("engine state changed without a transaction");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (act_i == ACT_ZERO) |=> (pos_q == '0) && (goal_q == '0))
    else $error("zero action left position or target set");

  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (act_i == ACT_TICK) |=> (pos_q == $past(pos_q)) ||
      (pos_q == $past(pos_q) + POS_W'(1)) || (pos_q == $past(pos_q) - POS_W'(1)))
    else $error("tick moved position by more than one step");

  a_rise_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pulse_q) |-> pos_q != $past(pos_q))
    else $error("step line rose without a position change");
`endif

endmodule

// ===== rtl/stepper_pulse_position_tracker_core.sv =====
`timescale 1ns / 1ps

// step/direction pulse generator with a signed position count
//
// in_i carries one action per transaction (tick, set target, watch bounds,
// zero) plus a target value used by set target. out_o returns exactly one
// result per input transaction: step line, direction line, position and goal
// as they stand after that action.
// configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i, one
// register per clock; the user must write it only while no transaction is
// in flight, and the block itself does not enforce this.
// an accepted item waits in the input register and updates the state when
// it advances, at the same edge at which its result turns valid on out_o.
// throughput is one item per clock while out_o.ready stays high: the input
// register keeps accepting while the previous result is being taken.
// if the receiver holds out_o.ready low, the result holds, one more item
// waits in the input register, then in_i.ready drops until out_o drains.
// reset sets the on and off tick registers to 25, deadband to 1, clears the
// position, target and pulse, and empties both registers.
module stepper_pulse_position_tracker_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stpt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  stpt_in_if.sink                         in_i,
  stpt_out_if.source                      out_o
);
  import stpt_pkg::*;

  cfg_t                      cfg;
  result_t                   res;
  logic                      in_vld_q;
  logic [1:0]                act_q;
  logic signed [FIELD_W-1:0] tgt_q;
  logic                      out_vld_q;
  logic                      adv;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q <= in_i.action;
      tgt_q <= in_i.target;
    end
  end

  stpt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  stpt_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .act_i  (action_e'(act_q)),
    .tgt_i  (tgt_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_o.valid      = out_vld_q;
  assign out_o.step_level = res.step_level;
  assign out_o.dir_level  = res.dir_level;
  assign out_o.position   = res.position;
  assign out_o.goal       = res.goal;

endmodule
